@@ rtl/core/ffea_pkg.sv @@
// ----------------------------------------------------------------------------
// ffea_pkg
// Shared types and constants of the first-fit extent allocator.
// ----------------------------------------------------------------------------
package ffea_pkg;

  localparam int POOL_BYTES_DEF   = 4096;
  localparam int BLOCK_BYTES_DEF  = 16;
  localparam int EXTENT_SLOTS_DEF = 14;
  localparam int HEADER_BYTES_DEF = 4;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FIT  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ASCAN,
    S_ASHIFT,
    S_FCHECK,
    S_FSCAN,
    S_FSHIFT,
    S_MSCAN,
    S_MSHIFT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic idx_clr;
    logic idx_inc;
    logic sh_init_drop;
    logic sh_init_ins;
    logic trim;
    logic drop_step;
    logic ins_step;
    logic ins_write;
    logic merge_step;
    logic fin_alloc;
    logic fin_free;
    logic fin_err;
    logic [1:0] err_code;
  } ctl_t;

  typedef struct packed {
    logic op;
    logic fits;
    logic exact;
    logic scan_end;
    logic bad_free;
    logic full;
    logic ahead;
    logic sh_done;
    logic merge_end;
    logic adjacent;
    logic merge_en;
  } sts_t;

endpackage

@@ rtl/core/ffea_ctrl.sv @@
// ----------------------------------------------------------------------------
// ffea_ctrl
// Sequencer for allocate, free, table shifts and the coalesce walk.
// ----------------------------------------------------------------------------
module ffea_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_fire,
  input  logic             out_busy,
  input  ffea_pkg::sts_t   sts,
  output ffea_pkg::ctl_t   ctl,
  output logic             idle
);

  ffea_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ffea_pkg::S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    ctl = '0;
    idle = 1'b0;
    case (state)
      ffea_pkg::S_IDLE: begin
        idle = 1'b1;
        if (in_fire) begin
          ctl.load = 1'b1;
          ctl.idx_clr = 1'b1;
          state_next = ffea_pkg::S_FCHECK;
        end
      end
      ffea_pkg::S_FCHECK: begin
        if (sts.op == ffea_pkg::OP_ALLOC) begin
          state_next = ffea_pkg::S_ASCAN;
        end else if (sts.bad_free) begin
          ctl.fin_err = 1'b1;
          ctl.err_code = ffea_pkg::ST_FIT;
          state_next = ffea_pkg::S_DONE;
        end else if (sts.full) begin
          ctl.fin_err = 1'b1;
          ctl.err_code = ffea_pkg::ST_FULL;
          state_next = ffea_pkg::S_DONE;
        end else begin
          state_next = ffea_pkg::S_FSCAN;
        end
      end
      ffea_pkg::S_ASCAN: begin
        if (sts.scan_end) begin
          ctl.fin_err = 1'b1;
          ctl.err_code = ffea_pkg::ST_FIT;
          state_next = ffea_pkg::S_DONE;
        end else if (sts.fits) begin
          ctl.fin_alloc = 1'b1;
          if (sts.exact) begin
            ctl.sh_init_drop = 1'b1;
            state_next = ffea_pkg::S_ASHIFT;
          end else begin
            ctl.trim = 1'b1;
            state_next = ffea_pkg::S_DONE;
          end
        end else begin
          ctl.idx_inc = 1'b1;
        end
      end
      ffea_pkg::S_ASHIFT: begin
        if (sts.sh_done) state_next = ffea_pkg::S_DONE;
        else             ctl.drop_step = 1'b1;
      end
      ffea_pkg::S_FSCAN: begin
        if (sts.scan_end || sts.ahead) begin
          ctl.sh_init_ins = 1'b1;
          state_next = ffea_pkg::S_FSHIFT;
        end else begin
          ctl.idx_inc = 1'b1;
        end
      end
      ffea_pkg::S_FSHIFT: begin
        if (sts.sh_done) begin
          ctl.ins_write = 1'b1;
          ctl.fin_free = 1'b1;
          ctl.idx_clr = 1'b1;
          state_next = sts.merge_en ? ffea_pkg::S_MSCAN : ffea_pkg::S_DONE;
        end else begin
          ctl.ins_step = 1'b1;
        end
      end
      ffea_pkg::S_MSCAN: begin
        if (sts.merge_end) begin
          state_next = ffea_pkg::S_DONE;
        end else if (sts.adjacent) begin
          ctl.merge_step = 1'b1;
          state_next = ffea_pkg::S_MSHIFT;
        end else begin
          ctl.idx_inc = 1'b1;
        end
      end
      ffea_pkg::S_MSHIFT: begin
        if (sts.sh_done) state_next = ffea_pkg::S_MSCAN;
        else             ctl.drop_step = 1'b1;
      end
      ffea_pkg::S_DONE: begin
        if (!out_busy) state_next = ffea_pkg::S_IDLE;
      end
      default: state_next = ffea_pkg::S_IDLE;
    endcase
  end

endmodule

@@ rtl/core/ffea_dp.sv @@
// ----------------------------------------------------------------------------
// ffea_dp
// Extent table, used-block count and result registers.
// ----------------------------------------------------------------------------
module ffea_dp #(
  parameter int POOL_BYTES   = ffea_pkg::POOL_BYTES_DEF,
  parameter int BLOCK_BYTES  = ffea_pkg::BLOCK_BYTES_DEF,
  parameter int EXTENT_SLOTS = ffea_pkg::EXTENT_SLOTS_DEF,
  parameter int HEADER_BYTES = ffea_pkg::HEADER_BYTES_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  ffea_pkg::ctl_t           ctl,
  input  logic                     merge_on_free,
  input  logic                     in_opcode,
  input  logic [12:0]              in_request_bytes,
  input  logic [11:0]              in_free_address,
  input  logic [8:0]               in_free_block_count,
  output ffea_pkg::sts_t           sts,
  output logic [1:0]               status,
  output logic [11:0]              user_address,
  output logic [11:0]              header_address,
  output logic [8:0]               header_value,
  output logic [12:0]              used_bytes
);

  localparam int POOL_BLOCKS = POOL_BYTES / BLOCK_BYTES;
  localparam int BW  = $clog2(POOL_BLOCKS + 1);
  localparam int IW  = $clog2(EXTENT_SLOTS);
  localparam int CW  = $clog2(EXTENT_SLOTS + 1);
  localparam int SH  = $clog2(BLOCK_BYTES);
  localparam int AW  = $clog2(POOL_BYTES) + 2;

  logic [BW-1:0] base [EXTENT_SLOTS];
  logic [BW-1:0] len  [EXTENT_SLOTS];
  logic [CW-1:0] count;
  logic [BW-1:0] used;
  logic [CW-1:0] idx;
  logic [CW-1:0] sh;
  logic          sh_ins;
  logic          op;
  logic [AW-1:0] req_blocks;
  logic [AW-1:0] faddr;
  logic [AW-1:0] fblk;
  logic [BW-1:0] fcnt;

  logic [AW-1:0] total;
  logic [IW-1:0] ix, ix1, shx, shx1;
  logic [BW:0]   used_sum;

  assign total = AW'(in_request_bytes) + AW'(HEADER_BYTES) + AW'(BLOCK_BYTES - 1);
  assign ix   = idx[IW-1:0];
  assign ix1  = IW'(idx + CW'(1));
  assign shx  = sh[IW-1:0];
  assign shx1 = IW'(sh + CW'(1));
  assign used_sum = (BW+1)'(used) + (BW+1)'(req_blocks);

  always_comb begin
    sts.op        = op;
    sts.scan_end  = idx >= count;
    sts.fits      = AW'(len[ix]) >= req_blocks;
    sts.exact     = AW'(len[ix]) == req_blocks;
    sts.bad_free  = faddr < AW'(HEADER_BYTES) || fcnt == '0 ||
                    fblk >= AW'(POOL_BLOCKS) ||
                    AW'(fcnt) > AW'(POOL_BLOCKS) - fblk;
    sts.full      = count >= CW'(EXTENT_SLOTS);
    sts.ahead     = fblk < AW'(base[ix]);
    sts.merge_end = idx + CW'(1) >= count;
    sts.adjacent  = (AW'(base[ix]) + AW'(len[ix])) == AW'(base[ix1]);
    sts.merge_en  = merge_on_free;
    // drop walks run against the already-decremented count
    if (sh_ins) sts.sh_done = sh <= idx;
    else        sts.sh_done = sh >= count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < EXTENT_SLOTS; k++) begin
        base[k] <= '0;
        len[k]  <= '0;
      end
      len[0] <= BW'(POOL_BLOCKS);
      count  <= CW'(1);
      used   <= '0;
      idx    <= '0;
      sh     <= '0;
      sh_ins <= 1'b0;
    end else begin
      if (ctl.idx_clr) idx <= '0;
      if (ctl.idx_inc) idx <= idx + CW'(1);
      if (ctl.sh_init_drop) begin
        sh <= idx;
        sh_ins <= 1'b0;
      end
      if (ctl.sh_init_ins) begin
        sh <= count;
        sh_ins <= 1'b1;
      end
      if (ctl.drop_step) begin
        base[shx] <= base[shx1];
        len[shx]  <= len[shx1];
        sh <= sh + CW'(1);
      end
      if (ctl.ins_step) begin
        base[shx] <= base[IW'(sh - CW'(1))];
        len[shx]  <= len[IW'(sh - CW'(1))];
        sh <= sh - CW'(1);
      end
      if (ctl.trim) begin
        base[ix] <= base[ix] + BW'(req_blocks);
        len[ix]  <= len[ix] - BW'(req_blocks);
      end
      if (ctl.fin_alloc) begin
        used <= (used_sum > (BW+1)'(POOL_BLOCKS)) ? BW'(POOL_BLOCKS) : BW'(used_sum);
        if (sts.exact) count <= count - CW'(1);
      end
      if (ctl.ins_write) begin
        base[ix] <= BW'(fblk);
        len[ix]  <= fcnt;
        count <= count + CW'(1);
        used <= (used > fcnt) ? used - fcnt : '0;
      end
      if (ctl.merge_step) begin
        len[ix] <= len[ix] + len[ix1];
        sh <= idx + CW'(1);
        sh_ins <= 1'b0;
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op         <= in_opcode;
      req_blocks <= total >> SH;
      faddr      <= AW'(in_free_address);
      fblk       <= (AW'(in_free_address) - AW'(HEADER_BYTES)) >> SH;
      fcnt       <= BW'(in_free_block_count);
    end
    if (ctl.fin_alloc) begin
      status         <= ffea_pkg::ST_OK;
      header_address <= 12'((AW'(base[ix])) << SH);
      user_address   <= 12'(((AW'(base[ix])) << SH) + AW'(HEADER_BYTES));
      header_value   <= 9'(req_blocks);
      used_bytes     <= 13'(((AW+BW)'(used_sum > (BW+1)'(POOL_BLOCKS) ?
                        BW'(POOL_BLOCKS) : BW'(used_sum))) << SH);
    end
    if (ctl.fin_free) begin
      status         <= ffea_pkg::ST_OK;
      user_address   <= 12'(faddr);
      header_address <= 12'(faddr - AW'(HEADER_BYTES));
      header_value   <= 9'(fcnt);
      used_bytes     <= 13'(((AW+BW)'((used > fcnt) ? used - fcnt : BW'(0))) << SH);
    end
    if (ctl.fin_err) begin
      status         <= ctl.err_code;
      user_address   <= '0;
      header_address <= '0;
      header_value   <= '0;
      used_bytes     <= 13'(((AW+BW)'(used)) << SH);
    end
  end

endmodule

@@ rtl/core/first_fit_extent_allocator_core.sv @@
// ----------------------------------------------------------------------------
// first_fit_extent_allocator_core
// First-fit block allocator over an address-sorted free extent table.
// ----------------------------------------------------------------------------
//  channel | dir | contents
//  s_axis  | in  | tdata: opcode, request_bytes, free_address, free_block_count
//  m_axis  | out | tdata: status, user_address, header_address, header_value,
//          |     |        used_bytes
//  cfg     | in  | merge_on_free
//  One item at a time. A rejected free ends without a scan. An allocate scans
//  the extents and shifts the table on an exact fit; a free scans for its
//  place and shifts the table to insert, and with merging a coalesce walk
//  runs after the result is offered.
//  Reset restores a single extent covering the whole pool, merging enabled.
//  The next beat and register writes wait for the walk and the result beat.
module first_fit_extent_allocator_core #(
  parameter int POOL_BYTES   = ffea_pkg::POOL_BYTES_DEF,
  parameter int BLOCK_BYTES  = ffea_pkg::BLOCK_BYTES_DEF,
  parameter int EXTENT_SLOTS = ffea_pkg::EXTENT_SLOTS_DEF,
  parameter int HEADER_BYTES = ffea_pkg::HEADER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // opcode, request_bytes, free_address, free_block_count
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // status, user_address, header_address, header_value,
                                     // used_bytes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  ffea_pkg::ctl_t ctl;
  ffea_pkg::sts_t sts;
  logic idle, merge_on_free, in_fire;
  logic [1:0]  status;
  logic [11:0] user_address, header_address;
  logic [8:0]  header_value;
  logic [12:0] used_bytes;

  assign cfg_ready = idle && !m_axis_tvalid;
  always_ff @(posedge clk) begin
    if (rst) merge_on_free <= 1'b1;
    else if (cfg_valid && cfg_ready) merge_on_free <= cfg_data;
  end

  assign s_axis_tready = idle && !m_axis_tvalid;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (ctl.fin_err || ctl.fin_alloc || ctl.fin_free) m_axis_tvalid <= 1'b1;
    else if (m_axis_tready) m_axis_tvalid <= 1'b0;
  end

  // result regs are final at fin; coalesce may still run behind the beat
  assign m_axis_tdata = {used_bytes, header_value, header_address,
                         user_address, status};

  ffea_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_busy(1'b0),
    .sts(sts), .ctl(ctl), .idle(idle)
  );

  ffea_dp #(
    .POOL_BYTES(POOL_BYTES), .BLOCK_BYTES(BLOCK_BYTES),
    .EXTENT_SLOTS(EXTENT_SLOTS), .HEADER_BYTES(HEADER_BYTES)
  ) u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .merge_on_free(merge_on_free),
    .in_opcode(s_axis_tdata[0]), .in_request_bytes(s_axis_tdata[13:1]),
    .in_free_address(s_axis_tdata[25:14]), .in_free_block_count(s_axis_tdata[34:26]),
    .sts(sts), .status(status), .user_address(user_address),
    .header_address(header_address), .header_value(header_value),
    .used_bytes(used_bytes)
  );

endmodule
